### design/pbgp_pkg.sv
// Shared constants and types for the priority bit gather placer.
`timescale 1ns / 1ps
`default_nettype none

package pbgp_pkg;

  // Code matrix geometry and store size.
  localparam int MATRIX_ROWS  = 14;
  localparam int DATA_COLUMNS = 256;
  localparam int MAX_BYTES    = 8192;

  // Field widths of the stream items.
  localparam int REQ_W  = 2;
  localparam int IDX_W  = 16;
  localparam int VAL_W  = 16;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 10;
  localparam int SYM_W  = 16;
  localparam int SIZE_W = 14;

  // Internal widths.
  localparam int BYTE_AW = $clog2(MAX_BYTES);
  localparam int PRIO_AW = 16;
  localparam int SYM_LOG = $clog2(SYM_W);
  localparam int EXT_W   = 17;
  localparam int DIV_MAX = (DATA_COLUMNS > MATRIX_ROWS) ? DATA_COLUMNS : MATRIX_ROWS;
  localparam int DIV_W   = $clog2(DIV_MAX + 1);

  // Quotients by the matrix sizes come from a rounded-up scaled reciprocal. With
  // this shift the rounding error stays small enough to be exact for every 16-bit
  // index and any divisor up to 1024.
  localparam int RECIP_SH = 26;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam logic [RECIP_W-1:0] ROWS_RECIP =
      RECIP_W'(((64'd1 << RECIP_SH) + 64'(MATRIX_ROWS) - 64'd1) / 64'(MATRIX_ROWS));
  localparam logic [RECIP_W-1:0] COLS_RECIP =
      RECIP_W'(((64'd1 << RECIP_SH) + 64'(DATA_COLUMNS) - 64'd1) / 64'(DATA_COLUMNS));

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAPPING_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SIZE   = 2'd1;

  // Request kinds carried in the input tuser.
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_BYTE = 2'd0,
    REQ_LOAD_PRIO = 2'd1,
    REQ_QUERY     = 2'd2
  } req_e;

endpackage

`default_nettype wire

### design/pbgp_div.sv
// Division of a symbol index by the matrix row or column count: quotient registered first, remainder after.
`timescale 1ns / 1ps
`default_nettype none

module pbgp_div import pbgp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [IDX_W-1:0] dividend_i,
  input  wire logic             by_cols_i,
  output logic                  done_o,
  output logic [IDX_W-1:0]      quot_o,
  output logic [DIV_W-1:0]      rem_o
);

  localparam int PROD_W = IDX_W + RECIP_W;
  localparam int BACK_W = IDX_W + DIV_W;

  logic               busy_q;
  logic               by_cols_q;
  logic [IDX_W-1:0]   dvd_q;
  logic [IDX_W-1:0]   quot_q;
  logic [DIV_W-1:0]   rem_q;

  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;
  logic [DIV_W-1:0]   divisor;
  logic [BACK_W-1:0]  back;
  logic [IDX_W-1:0]   rem_full;

  // The quotient is the index times the scaled reciprocal, shifted back down.
  assign recip = by_cols_i ? COLS_RECIP : ROWS_RECIP;
  assign prod  = PROD_W'(dividend_i) * PROD_W'(recip);

  // The remainder is registered in the cycle after the quotient and is computed from the registered quotient.
  assign divisor  = by_cols_q ? DIV_W'(DATA_COLUMNS) : DIV_W'(MATRIX_ROWS);
  assign back     = BACK_W'(quot_q) * BACK_W'(divisor);
  assign rem_full = dvd_q - back[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q     <= dividend_i;
      quot_q    <= prod[RECIP_SH +: IDX_W];
      by_cols_q <= by_cols_i;
    end
    if (busy_q) begin
      rem_q <= rem_full[DIV_W-1:0];
    end
  end

  assign done_o = !busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && busy_q))
    else $error("divider restarted while busy");

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (back <= BACK_W'(dvd_q)))
    else $error("quotient too large for the dividend");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> (rem_q < divisor))
    else $error("final remainder not below divisor");

endmodule

`default_nettype wire

### design/priority_bit_gather_placer_unit.sv
// Top level: byte and priority stores, gather sequencer and matrix placement.
`timescale 1ns / 1ps
`default_nettype none

// Loads and ignored requests leave the sequencer idle, so the input stays ready for them. A
// priority-mode query issues one table read per gathered bit (nbits = 16, or 8 for an odd
// last symbol) into a two-stage read pipeline; a column-mode query reads its 2 bytes (1 when
// odd last), and a query beyond the symbols reads nothing and goes straight to its result.
// One query at a time; the input also stalls while a finished result waits for the output
// register. Reset (rst_ni low, async) clears control and configuration; stores are garbage.

module priority_bit_gather_placer_unit import pbgp_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write channel.
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [SIZE_W-1:0]    cfg_data_i,
  // Request stream.
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [31:0]          s_axis_tdata_i,  // item_index[15:0], item_value[31:16]
  input  wire logic [REQ_W-1:0]     s_axis_tuser_i,  // req_type[1:0]
  // Result stream.
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [31:0]               m_axis_tdata_o,  // matrix_row[3:0], matrix_column[13:4],
                                                     // symbol_value[29:14], zero[31:30]
  output logic [0:0]                m_axis_tuser_o   // dropped[0]
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_e;

  localparam int CNT_W = SYM_LOG + 1;

  // Configuration registers.
  logic                mode_q;
  logic [SIZE_W-1:0]   input_size_q;

  // Sequencer state and per-query registers.
  state_e              state_q;
  logic [IDX_W-1:0]    idx_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    nbits_q;
  logic                oob_q;
  logic [SYM_W-1:0]    sym_q;

  // Read pipeline: priority read stage, then byte read stage.
  logic                p1_valid_q;
  logic [SYM_LOG-1:0]  p1_j_q;
  logic [VAL_W-1:0]    prio_rdata_q;
  logic                b_valid_q;
  logic [SYM_LOG-1:0]  b_j_q;
  logic [2:0]          b_sel_q;
  logic                b_inr_q;
  logic [7:0]          byte_rdata_q;

  // Output register.
  logic                m_valid_q;
  logic [ROW_W-1:0]    out_row_q;
  logic [COL_W-1:0]    out_col_q;
  logic [SYM_W-1:0]    out_sym_q;
  logic                out_drop_q;

  // Stores.
  logic [7:0]          byte_mem [MAX_BYTES];
  logic [VAL_W-1:0]    prio_mem [2**PRIO_AW];

  logic [IDX_W-1:0]    in_idx;
  logic [VAL_W-1:0]    in_val;
  req_e                in_req;
  logic                in_acc;
  logic                cfg_acc;

  logic [EXT_W-1:0]    eff_size;
  logic [EXT_W-1:0]    nsym;
  logic [EXT_W-1:0]    nfull;
  logic                q_oob;
  logic                q_odd;

  logic                issue;
  logic [PRIO_AW-1:0]  prio_raddr;
  logic [EXT_W-1:0]    byte_addr_ext;
  logic [BYTE_AW-1:0]  byte_raddr;
  logic                byte_inr;
  logic                gather_bit;

  logic                div_start;
  logic                div_done;
  logic [IDX_W-1:0]    div_quot;
  logic [DIV_W-1:0]    div_rem;

  logic [IDX_W-1:0]    rem_ext;
  logic [IDX_W-1:0]    quot_half;
  logic [IDX_W-1:0]    alt_row;
  logic                fin_drop;
  logic [ROW_W-1:0]    fin_row;
  logic [COL_W-1:0]    fin_col;
  logic                out_free;

  assign in_idx  = s_axis_tdata_i[IDX_W-1:0];
  assign in_val  = s_axis_tdata_i[IDX_W+VAL_W-1:IDX_W];
  assign in_req  = req_e'(s_axis_tuser_i);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign cfg_acc         = cfg_valid_i && cfg_ready_o;

  // Effective size is the programmed size clipped to the store depth.
  assign eff_size = (EXT_W'(input_size_q) > EXT_W'(MAX_BYTES)) ? EXT_W'(MAX_BYTES)
                                                              : EXT_W'(input_size_q);
  assign nsym     = (eff_size + EXT_W'(1)) >> 1;
  assign nfull    = eff_size >> 1;
  assign q_oob    = (EXT_W'(in_idx) >= nsym);
  assign q_odd    = (EXT_W'(in_idx) >= nfull);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      input_size_q <= '0;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        CFG_MAPPING_MODE: mode_q       <= cfg_data_i[0];
        CFG_INPUT_SIZE:   input_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One read is issued per cycle until every wanted bit (or byte) is requested.
  assign issue = (state_q == S_RUN) && (cnt_q < nbits_q);

  // The priority entry index 16k+j wraps to the table depth.
  assign prio_raddr = {idx_q[PRIO_AW-SYM_LOG-1:0], cnt_q[SYM_LOG-1:0]};

  // In priority mode the byte address comes from the entry just read; in column
  // mode it is the byte pair of the symbol.
  assign byte_addr_ext = mode_q ? EXT_W'(prio_rdata_q[VAL_W-1:3])
                                : (EXT_W'({idx_q, 1'b0}) + EXT_W'(cnt_q));
  assign byte_raddr    = byte_addr_ext[BYTE_AW-1:0];
  assign byte_inr      = (byte_addr_ext < eff_size);

  always_ff @(posedge clk_i) begin
    if (in_acc && in_req == REQ_LOAD_BYTE && EXT_W'(in_idx) < EXT_W'(MAX_BYTES)) begin
      byte_mem[in_idx[BYTE_AW-1:0]] <= in_val[7:0];
    end
    byte_rdata_q <= byte_mem[byte_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_req == REQ_LOAD_PRIO) begin
      prio_mem[in_idx[PRIO_AW-1:0]] <= in_val;
    end
    prio_rdata_q <= prio_mem[prio_raddr];
  end

  // Input bits are numbered MSB first within a byte.
  assign gather_bit = byte_rdata_q[~b_sel_q] && b_inr_q;

  // The divider splits the symbol index into row and column for either mode.
  assign div_start = in_acc && (in_req == REQ_QUERY) && !q_oob;

  pbgp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_idx),
    .by_cols_i  (mode_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Placement. Priority mode fills rows alternately from the bottom and the top.
  assign rem_ext   = IDX_W'(div_rem);
  assign quot_half = div_quot >> 1;
  assign alt_row   = div_quot[0] ? quot_half : (IDX_W'(MATRIX_ROWS - 1) - quot_half);

  always_comb begin
    if (mode_q) begin
      fin_drop = (div_quot >= IDX_W'(MATRIX_ROWS));
      fin_row  = alt_row[ROW_W-1:0];
      fin_col  = rem_ext[COL_W-1:0];
    end else begin
      fin_drop = (div_quot >= IDX_W'(DATA_COLUMNS));
      fin_row  = rem_ext[ROW_W-1:0];
      fin_col  = div_quot[COL_W-1:0];
    end
  end

  assign out_free = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      p1_valid_q <= 1'b0;
      b_valid_q  <= 1'b0;
      m_valid_q  <= 1'b0;
      cnt_q      <= '0;
      nbits_q    <= '0;
      oob_q      <= 1'b0;
      idx_q      <= '0;
      sym_q      <= '0;
      p1_j_q     <= '0;
      b_j_q      <= '0;
      b_sel_q    <= '0;
      b_inr_q    <= 1'b0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_sym_q  <= '0;
      out_drop_q <= 1'b0;
    end else begin
      // A finished query refills the output register as the old result leaves.
      if (state_q == S_FIN && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      // Priority read stage feeds the byte read stage in priority mode.
      p1_valid_q <= issue && mode_q;
      p1_j_q     <= cnt_q[SYM_LOG-1:0];
      if (mode_q) begin
        b_valid_q <= p1_valid_q;
        b_j_q     <= p1_j_q;
        b_sel_q   <= prio_rdata_q[2:0];
      end else begin
        b_valid_q <= issue;
        b_j_q     <= cnt_q[SYM_LOG-1:0];
        b_sel_q   <= '0;
      end
      b_inr_q <= byte_inr;

      // Collect gathered bits, or the bytes of a pair in column mode.
      if (b_valid_q) begin
        if (mode_q) begin
          sym_q[~b_j_q] <= gather_bit;
        end else if (b_j_q == '0) begin
          sym_q[SYM_W-1:8] <= b_inr_q ? byte_rdata_q : 8'd0;
        end else begin
          sym_q[7:0] <= b_inr_q ? byte_rdata_q : 8'd0;
        end
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc && in_req == REQ_QUERY) begin
            idx_q <= in_idx;
            cnt_q <= '0;
            sym_q <= '0;
            oob_q <= q_oob;
            if (mode_q) begin
              nbits_q <= q_odd ? CNT_W'(SYM_W / 2) : CNT_W'(SYM_W);
            end else begin
              nbits_q <= q_odd ? CNT_W'(1) : CNT_W'(2);
            end
            state_q <= q_oob ? S_FIN : S_RUN;
          end
        end
        S_RUN: begin
          if (issue) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end else if (!p1_valid_q && !b_valid_q && div_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (oob_q) begin
              out_row_q  <= '0;
              out_col_q  <= '0;
              out_sym_q  <= '0;
              out_drop_q <= 1'b1;
            end else begin
              out_row_q  <= fin_drop ? '0 : fin_row;
              out_col_q  <= fin_drop ? '0 : fin_col;
              out_sym_q  <= sym_q;
              out_drop_q <= fin_drop;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_sym_q, out_col_q, out_row_q};
  assign m_axis_tuser_o  = out_drop_q;

  a_drop_no_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o[13:0] == 14'd0))
    else $error("dropped symbol carries a matrix position");

  a_byte_after_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && mode_q) |-> $past(p1_valid_q))
    else $error("byte read without a preceding priority read");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (cnt_q <= nbits_q))
    else $error("more reads issued than bits wanted");

  a_fin_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> div_done)
    else $error("result formed before the divider finished");

endmodule

`default_nettype wire

### verif/tb_priority_bit_gather_placer_unit.sv
// Self-checking testbench for the priority bit gather placer unit.
`timescale 1ns / 1ps

module tb_priority_bit_gather_placer_unit;
  import pbgp_pkg::*;

  // Request kind that the unit must swallow without an answer.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int ITEMS_PER_PHASE = 225;
  // Settle time after draining; it covers any work still in flight.
  localparam int SETTLE_CYCLES   = 40;
  localparam int LONG_HOLD       = 200;
  // Cycles without any handshake (accepted item, delivered result or register write) before the run is declared hung.
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int REPORT_CAP      = 200;

  typedef struct {
    logic [REQ_W-1:0] kind;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
  } request_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [SYM_W-1:0] symbol;
    logic             dropped;
  } placement_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = '0;
  logic [SIZE_W-1:0]    cfg_data_i      = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [31:0]          s_axis_tdata_i  = '0;
  logic [REQ_W-1:0]     s_axis_tuser_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [31:0]          m_axis_tdata_o;
  logic [0:0]           m_axis_tuser_o;

  priority_bit_gather_placer_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Items waiting for the driver and placements waiting for the unit.
  request_t   pending_requests[$];
  placement_t expected_placements[$];

  // Predictor state, updated only when the unit accepts an item or a register write.
  logic [7:0]        byte_mem [MAX_BYTES];
  logic [15:0]       prio_mem [65536];
  logic              active_mode = 1'b0;
  int unsigned       active_size = 0;

  // Stimulus planning state. It runs ahead of the unit, shapes the items queued and keeps
  // every store read the unit performs on an entry that has been written.
  bit                byte_loaded  [MAX_BYTES];
  bit                prio_loaded  [65536];
  logic [15:0]       prio_planned [65536];
  logic              plan_mode = 1'b0;
  int unsigned       plan_size = 0;
  int unsigned       stim_count = 0;

  int unsigned       items_queued   = 0;
  int unsigned       items_accepted = 0;
  int unsigned       result_count   = 0;
  int unsigned       mismatches     = 0;
  int unsigned       quiet_cycles   = 0;

  // Handshakes seen at the last rising edge; the drivers act on them at the falling edge.
  bit                req_taken    = 1'b0;
  bit                result_taken = 1'b0;
  bit                cfg_taken    = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A byte past the valid input size reads as zero; the store is never touched then.
  function automatic logic [7:0] stored_byte(input int unsigned addr, input int unsigned eff);
    return (addr < eff) ? byte_mem[addr] : 8'h00;
  endfunction

  task automatic predict_placement(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx,
                                   input logic [VAL_W-1:0] val);
    placement_t  res;
    int unsigned k, eff, nsym, nbits, blk, src;
    logic [7:0]  octet;
    res  = '0;
    k    = idx;
    eff  = (active_size > MAX_BYTES) ? MAX_BYTES : active_size;
    nsym = (eff + 1) / 2;
    case (kind)
      REQ_LOAD_BYTE: begin
        // Addresses past the store are dropped silently.
        if (k < MAX_BYTES) byte_mem[k] = val[7:0];
      end
      REQ_LOAD_PRIO: begin
        prio_mem[k] = val;
      end
      REQ_QUERY: begin
        if (k >= nsym) begin
          // No such symbol: everything zero, flagged as dropped.
          res.dropped = 1'b1;
        end else if (active_mode) begin
          // The odd last symbol only gathers its high byte.
          nbits = (k >= eff / 2) ? 8 : 16;
          for (int j = 0; j < nbits; j++) begin
            src   = prio_mem[(16 * k + j) & 32'hFFFF];
            octet = stored_byte(src >> 3, eff);
            res.symbol[15 - j] = octet[7 - (src % 8)];
          end
          // Rows alternate: bottom row first, then the top, working inward.
          blk = k / DATA_COLUMNS;
          if (blk >= MATRIX_ROWS) begin
            res.dropped = 1'b1;
          end else begin
            res.column = COL_W'(k % DATA_COLUMNS);
            res.row    = ROW_W'(blk[0] ? (blk >> 1) : (MATRIX_ROWS - 1 - (blk >> 1)));
          end
        end else begin
          res.symbol = {stored_byte(2 * k, eff),
                        (k >= eff / 2) ? 8'h00 : stored_byte(2 * k + 1, eff)};
          blk = k / MATRIX_ROWS;
          if (blk >= DATA_COLUMNS) begin
            res.dropped = 1'b1;
          end else begin
            res.row    = ROW_W'(k % MATRIX_ROWS);
            res.column = COL_W'(blk);
          end
        end
        expected_placements.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus planning
  // ---------------------------------------------------------------------------

  task automatic push_item(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val);
    request_t r;
    r.kind = kind;
    r.idx  = idx;
    r.val  = val;
    pending_requests.push_back(r);
    items_queued++;
    if (kind == REQ_LOAD_PRIO) begin
      prio_loaded[idx]  = 1'b1;
      prio_planned[idx] = val;
    end
    if (kind == REQ_LOAD_BYTE && idx < MAX_BYTES) byte_loaded[idx] = 1'b1;
    // Items the unit ignores do not count toward the phase length.
    if (kind != REQ_UNUSED && !(kind == REQ_LOAD_BYTE && idx >= MAX_BYTES)) stim_count++;
  endtask

  // Source bit numbers: mostly inside the first bytes so entries get reused, some
  // straddling the end of the valid data, the rest anywhere.
  function automatic logic [15:0] pick_source_bit();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 16'($urandom_range(0, 255));
    if (sel < 7) return 16'(plan_size * 8 + $urandom_range(0, 15) - 8);
    return 16'($urandom);
  endfunction

  task automatic ensure_byte(input int unsigned addr);
    if (addr < plan_size && !byte_loaded[addr])
      push_item(REQ_LOAD_BYTE, 16'(addr), 16'($urandom));
  endtask

  // A query preceded by whatever loads it needs so that every store read hits
  // a written entry.
  task automatic push_query(input int unsigned k);
    int unsigned entry;
    if (plan_mode) begin
      for (int j = 0; j < ((k >= plan_size / 2) ? 8 : 16); j++) begin
        entry = (16 * k + j) & 32'hFFFF;
        if (!prio_loaded[entry]) push_item(REQ_LOAD_PRIO, 16'(entry), pick_source_bit());
        ensure_byte(prio_planned[entry] >> 3);
      end
    end else begin
      ensure_byte(2 * k);
      ensure_byte(2 * k + 1);
    end
    push_item(REQ_QUERY, 16'(k), 16'($urandom));
  endtask

  // Symbol indexes lean toward reused low entries, the last symbol, row edges in
  // priority mode and the last placeable column in column mode.
  function automatic int unsigned pick_symbol(input int unsigned nsym);
    int unsigned sel, k;
    sel = $urandom_range(0, 99);
    if (sel < 40)
      k = $urandom_range(0, ((nsym < 32) ? nsym : 32) - 1);
    else if (sel < 55)
      k = nsym - 1;
    else if (sel < 70)
      k = $urandom_range(0, (nsym - 1) / DATA_COLUMNS) * DATA_COLUMNS + $urandom_range(0, 1) - 1;
    else if (sel < 80)
      k = (MATRIX_ROWS * DATA_COLUMNS) - 2 + $urandom_range(0, 3);
    else
      k = $urandom_range(0, nsym - 1);
    return (k < nsym) ? k : nsym - 1;
  endfunction

  task automatic random_step();
    int unsigned nsym, sel;
    nsym = (plan_size + 1) / 2;
    sel  = $urandom_range(0, 99);
    if (sel < 65 && nsym != 0)
      push_query(pick_symbol(nsym));
    else if (sel < 75)
      push_item(REQ_QUERY, 16'($urandom_range(nsym, 65535)), 16'($urandom));
    else if (sel < 85)
      push_item(REQ_LOAD_BYTE, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                 : 16'($urandom_range(0, MAX_BYTES - 1)), 16'($urandom));
    else if (sel < 95)
      push_item(REQ_LOAD_PRIO, 16'($urandom), pick_source_bit());
    else
      push_item(REQ_UNUSED, 16'($urandom), 16'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Configuration and phase control
  // ---------------------------------------------------------------------------

  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [SIZE_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_config(input logic mode, input int unsigned size);
    write_register(CFG_MAPPING_MODE, SIZE_W'(mode));
    write_register(CFG_INPUT_SIZE, SIZE_W'(size));
    plan_mode = mode;
    plan_size = (size > MAX_BYTES) ? MAX_BYTES : size;
  endtask

  // Every queued item accepted and every placement delivered, then a settling wait
  // for a trailing load that produces no result.
  task automatic wait_until_drained();
    do @(negedge clk_i); while (items_accepted != items_queued || expected_placements.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: one item at a time from the pending queue, with a random
  // gap after each item and occasional runs without gaps.
  // ---------------------------------------------------------------------------
  int unsigned send_gap  = 0;
  bit          send_calm = 1'b0;

  always @(negedge clk_i) begin
    request_t r;
    if (rst_ni && (!s_axis_tvalid_i || req_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        r = pending_requests.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {r.val, r.idx};
        s_axis_tuser_i  <= r.kind;
        if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 4);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: after each result it holds tready low for a random wait.
  // Twice in the run it holds off for a long stretch so that the unit backs up
  // and stalls its request input while the driver keeps offering items.
  // ---------------------------------------------------------------------------
  int unsigned recv_wait = 0;
  bit          recv_calm = 1'b0;

  always @(negedge clk_i) begin
    if (result_taken) begin
      if (result_count == 40 || result_count == 250) begin
        recv_wait = LONG_HOLD;
      end else begin
        if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 4);
      end
    end
    if (recv_wait != 0) begin
      recv_wait--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples all handshakes at the rising edge, checks each result
  // against the oldest expected placement and feeds accepted items to the
  // predictor. A watchdog ends the run if nothing moves for too long.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      // Printing stops after REPORT_CAP mismatches so a broken build cannot flood the log.
      if (mismatches <= REPORT_CAP)
        $display("time %0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    placement_t got, want;
    req_taken    = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    result_taken = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    cfg_taken    = rst_ni && cfg_valid_i && cfg_ready_o;

    if (result_taken) begin
      result_count++;
      got.row     = m_axis_tdata_o[3:0];
      got.column  = m_axis_tdata_o[13:4];
      got.symbol  = m_axis_tdata_o[29:14];
      got.dropped = m_axis_tuser_o[0];
      if (expected_placements.size() == 0) begin
        mismatches++;
        $display("time %0t: result with none expected, expected nothing, actual row %0d col %0d sym %h drop %0d",
                 $time, got.row, got.column, got.symbol, got.dropped);
      end else begin
        want = expected_placements.pop_front();
        compare_field("matrix_row", want.row, got.row);
        compare_field("matrix_column", want.column, got.column);
        compare_field("symbol_value", want.symbol, got.symbol);
        compare_field("dropped", want.dropped, got.dropped);
      end
    end

    if (cfg_taken) begin
      if (cfg_index_i == CFG_MAPPING_MODE) active_mode = cfg_data_i[0];
      else if (cfg_index_i == CFG_INPUT_SIZE) active_size = cfg_data_i;
    end

    if (req_taken) begin
      items_accepted++;
      predict_placement(s_axis_tuser_i, s_axis_tdata_i[15:0], s_axis_tdata_i[31:16]);
    end

    if (req_taken || result_taken || cfg_taken) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("priority_bit_gather_placer_unit test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic        mode;
    int unsigned size;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration holds no symbols: every query falls beyond the end.
    // Unused request kinds and byte loads past the store must stay silent.
    push_item(REQ_QUERY, 16'h0000, 16'hFFFF);
    push_item(REQ_QUERY, 16'hFFFF, 16'h0000);
    push_item(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
    push_item(REQ_LOAD_BYTE, 16'hFFFF, 16'hFFFF);
    push_item(REQ_LOAD_BYTE, 16'(MAX_BYTES), 16'h00FF);
    wait_until_drained();

    // Priority mode with a single byte: the only symbol is the odd last one and
    // gathers eight bits, some from the valid byte and some from past the end.
    apply_config(1'b1, 1);
    push_item(REQ_LOAD_BYTE, 16'h0000, 16'h5AA5);
    push_item(REQ_LOAD_PRIO, 16'd0, 16'd0);
    push_item(REQ_LOAD_PRIO, 16'd1, 16'd7);
    push_item(REQ_LOAD_PRIO, 16'd2, 16'd8);
    push_item(REQ_LOAD_PRIO, 16'd3, 16'hFFFF);
    push_item(REQ_LOAD_PRIO, 16'd4, 16'd1);
    push_item(REQ_LOAD_PRIO, 16'd5, 16'd6);
    push_item(REQ_LOAD_PRIO, 16'd6, 16'd3);
    push_item(REQ_LOAD_PRIO, 16'd7, 16'd4);
    push_query(0);
    push_item(REQ_QUERY, 16'd1, 16'h0000);
    wait_until_drained();

    // Column mode, odd size near the top: the odd last symbol lands past the
    // last column and is dropped; the last placeable slot and the first dropped
    // one sit either side of the column limit.
    apply_config(1'b0, MAX_BYTES - 1);
    push_query(MAX_BYTES / 2 - 1);
    push_query(MATRIX_ROWS * DATA_COLUMNS - 1);
    push_query(MATRIX_ROWS * DATA_COLUMNS);
    push_query(0);
    push_item(REQ_QUERY, 16'(MAX_BYTES / 2), 16'h0000);

    // Random phases: both modes, full and empty stores, odd and even sizes.
    for (int phase = 0; phase < 8; phase++) begin
      wait_until_drained();
      case (phase)
        0: begin mode = 1'b1; size = MAX_BYTES; end
        1: begin mode = 1'b0; size = MAX_BYTES; end
        2: begin mode = 1'b1; size = 2 * $urandom_range(0, 49) + 1; end
        3: begin mode = 1'b0; size = $urandom_range(0, 40); end
        4: begin mode = 1'b1; size = $urandom_range(MATRIX_ROWS * DATA_COLUMNS * 2 + 1, MAX_BYTES); end
        5: begin mode = 1'b0; size = 0; end
        6: begin mode = 1'b1; size = $urandom_range(0, MAX_BYTES); end
        default: begin mode = 1'b0; size = $urandom_range(1, MAX_BYTES); end
      endcase
      apply_config(mode, size);
      stim_count = 0;
      while (stim_count < ITEMS_PER_PHASE) random_step();
    end

    wait_until_drained();
    if (mismatches == 0) begin
      $display("priority_bit_gather_placer_unit test passed");
    end else begin
      $display("priority_bit_gather_placer_unit test failed");
    end
    $finish;
  end

endmodule
